@@ design/pointer_shake_detector_defines.svh @@
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef POINTER_SHAKE_DETECTOR_DEFINES_SVH
`define POINTER_SHAKE_DETECTOR_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define PSD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence in the same cycle.
`define PSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the next cycle.
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/psd_pkg.sv @@
package psd_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int COORD_WIDTH   = 20;

  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int MAG_W   = COORD_WIDTH;
  localparam int ROOT_W  = MAG_W + 1;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int STEP_W  = $clog2(ROOT_W);
  localparam int TRAIL_W = ROOT_W + SLOT_W;
  localparam int PROD_W  = ROOT_W + 4;
  localparam int CMP_W   = (TRAIL_W > PROD_W) ? TRAIL_W : PROD_W;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_WINDOW    = 2'd0,
    REG_MIN_DIAG  = 2'd1,
    REG_RATIO     = 2'd2,
    REG_TOLERANCE = 2'd3
  } reg_idx_t;

  localparam logic [15:0] WINDOW_RST    = 16'd500;
  localparam logic [19:0] MIN_DIAG_RST  = 20'd1600;
  localparam logic [3:0]  RATIO_RST     = 4'd4;
  localparam logic [7:0]  TOLERANCE_RST = 8'd16;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    coord_t      x;
    coord_t      y;
    logic [31:0] stamp;
  } hist_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AGE_RQ,
    ST_AGE_CK,
    ST_MRG_RQ1,
    ST_MRG_RQ2,
    ST_MRG_CK,
    ST_APPEND,
    ST_WALK_RQ,
    ST_WALK_DAT,
    ST_WALK_WAIT,
    ST_DIAG_GO,
    ST_DIAG_WAIT,
    ST_RESULT
  } psd_state_t;

  typedef enum logic [1:0] {
    HY_IDLE,
    HY_MUL_A,
    HY_MUL_B,
    HY_ROOT
  } hyp_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hyp_stat_t;

  function automatic slot_t slot_inc(slot_t s);
    slot_t r;
    if (s == slot_t'(HISTORY_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

  function automatic slot_t slot_dec(slot_t s);
    slot_t r;
    if (s == '0) begin
      r = slot_t'(HISTORY_DEPTH - 1);
    end else begin
      r = s - slot_t'(1);
    end
    return r;
  endfunction

endpackage

@@ design/psd_if.sv @@
interface psd_in_if;
  logic                  valid;
  logic                  ready;
  psd_pkg::coord_t       pos_x;
  psd_pkg::coord_t       pos_y;
  logic [31:0]           stamp_ms;

  modport source (output valid, pos_x, pos_y, stamp_ms, input ready);
  modport sink   (input valid, pos_x, pos_y, stamp_ms, output ready);
endinterface

interface psd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      shaken;
  logic [6:0]                history_count;

  modport source (output valid, shaken, history_count, input ready);
  modport sink   (input valid, shaken, history_count, output ready);
endinterface

@@ design/psd_hypot.sv @@
module psd_hypot (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [psd_pkg::MAG_W-1:0]        op_a,
  input  logic [psd_pkg::MAG_W-1:0]        op_b,
  output psd_pkg::hyp_stat_t               stat,
  output logic [psd_pkg::ROOT_W-1:0]       root
);

  localparam int RW = psd_pkg::ROOT_W;

  psd_pkg::hyp_state_t state_r, state_nxt;
  logic [psd_pkg::MAG_W-1:0]    a_r, b_r;
  logic [2*psd_pkg::MAG_W-1:0]  prod_r;
  logic [psd_pkg::RAD_W-1:0]    rad_r;
  logic [RW-1:0]                root_r;
  logic [RW:0]                  rem_r;
  logic [psd_pkg::STEP_W-1:0]   step_r;
  logic                         done_r;

  logic [psd_pkg::MAG_W-1:0]    mul_op;
  logic [2*psd_pkg::MAG_W-1:0]  mul_res;
  logic [RW+2:0]                rem_sh, trial, rem_diff;
  logic                         take;

  assign mul_op   = (state_r == psd_pkg::HY_MUL_A) ? a_r : b_r;
  assign mul_res  = mul_op * mul_op;
  assign rem_sh   = {rem_r, rad_r[psd_pkg::RAD_W-1 -: 2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign rem_diff = rem_sh - trial;
  assign take     = (rem_sh >= trial);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psd_pkg::HY_IDLE:  if (start) state_nxt = psd_pkg::HY_MUL_A;
      psd_pkg::HY_MUL_A: state_nxt = psd_pkg::HY_MUL_B;
      psd_pkg::HY_MUL_B: state_nxt = psd_pkg::HY_ROOT;
      psd_pkg::HY_ROOT:  if (step_r == '0) state_nxt = psd_pkg::HY_IDLE;
      default:           state_nxt = psd_pkg::HY_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state_r != psd_pkg::HY_IDLE);
    stat.done = done_r;
    root      = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psd_pkg::HY_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == psd_pkg::HY_ROOT) && (step_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      psd_pkg::HY_IDLE: begin
        a_r <= op_a;
        b_r <= op_b;
      end
      psd_pkg::HY_MUL_A: prod_r <= mul_res;
      psd_pkg::HY_MUL_B: begin
        rad_r  <= psd_pkg::RAD_W'(prod_r) + psd_pkg::RAD_W'(mul_res);
        root_r <= '0;
        rem_r  <= '0;
        step_r <= psd_pkg::STEP_W'(RW - 1);
      end
      psd_pkg::HY_ROOT: begin
        // One radicand bit pair per cycle, restoring method.
        rad_r  <= rad_r << 2;
        step_r <= step_r - psd_pkg::STEP_W'(1);
        if (take) begin
          rem_r  <= rem_diff[RW:0];
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[RW:0];
          root_r <= {root_r[RW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/pointer_shake_detector.sv @@
// Pointer shake detector.
// Motion words enter on in_ch (pos_x, pos_y in signed Q16.4 pixels and a
// wrapping millisecond stamp); each accepted word yields exactly one result
// word on out_ch (shaken flag and the number of points held afterwards).
// Thresholds are set through the APB-style cfg_ port; the user must write
// them only while idle, since the block itself does not enforce this.
// in_ch.ready is high only while the sequencer is idle; one word is worked
// on at a time. A word first ages out expired points, then runs the
// direction check and, when it is appended, measures each held segment
// and then the bounding-box diagonal. These steps use the single
// multiplier and square-root unit, which takes one bit of root per cycle,
// and the single history memory read port; the history holds 64 points.
// A finished result sits in the output register until out_ch.ready; the next
// input word is taken meanwhile, and a later result waits for that register.
// Reset (rst_n low, synchronous) empties the history and loads the default
// thresholds; the history memory itself is not cleared.
`include "pointer_shake_detector_defines.svh"

module pointer_shake_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  psd_in_if.sink                             in_ch,
  psd_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [psd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [psd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [psd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int CW = psd_pkg::COORD_WIDTH;

  // Configuration registers.
  logic [15:0] window_r;
  logic [19:0] min_diag_r;
  logic [3:0]  ratio_r;
  logic [7:0]  tol_r;
  logic        cfg_wr;
  psd_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = psd_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= psd_pkg::WINDOW_RST;
      min_diag_r <= psd_pkg::MIN_DIAG_RST;
      ratio_r    <= psd_pkg::RATIO_RST;
      tol_r      <= psd_pkg::TOLERANCE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        psd_pkg::REG_WINDOW:    window_r   <= cfg_pwdata[15:0];
        psd_pkg::REG_MIN_DIAG:  min_diag_r <= cfg_pwdata[19:0];
        psd_pkg::REG_RATIO:     ratio_r    <= cfg_pwdata[3:0];
        psd_pkg::REG_TOLERANCE: tol_r      <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      psd_pkg::REG_WINDOW:    cfg_prdata = {16'd0, window_r};
      psd_pkg::REG_MIN_DIAG:  cfg_prdata = {12'd0, min_diag_r};
      psd_pkg::REG_RATIO:     cfg_prdata = {28'd0, ratio_r};
      psd_pkg::REG_TOLERANCE: cfg_prdata = {24'd0, tol_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // History memory.
  psd_pkg::hist_ent_t mem [psd_pkg::HISTORY_DEPTH];
  psd_pkg::hist_ent_t rd_data_r, wr_data;
  psd_pkg::slot_t     rd_addr, wr_addr;
  logic               mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer state.
  psd_pkg::psd_state_t state_r, state_nxt;
  psd_pkg::slot_t      oldest_r, next_r, walk_idx_r;
  logic [psd_pkg::CNT_W-1:0] held_r, seg_cnt_r;
  psd_pkg::coord_t     cur_x_r, cur_y_r, last_x_r, last_y_r;
  psd_pkg::coord_t     prev_x_r, prev_y_r;
  psd_pkg::coord_t     min_x_r, max_x_r, min_y_r, max_y_r;
  logic [31:0]         cur_t_r;
  logic [psd_pkg::TRAIL_W-1:0] trail_r;
  logic                res_shaken_r;

  logic                out_valid_r, out_shaken_r;
  logic [6:0]          out_count_r;

  logic                in_acc, res_load, hyp_start;
  logic [psd_pkg::MAG_W-1:0]  hyp_a, hyp_b;
  logic [psd_pkg::ROOT_W-1:0] hyp_root;
  psd_pkg::hyp_stat_t  hyp_stat;

  // Derived values.
  logic [31:0]         age;
  logic                expired, agree_ok, full;
  logic signed [CW:0]  ax, bx, ay, by, sx, sy;
  logic signed [CW+1:0] tol_s;
  logic [CW:0]         mx, my;
  logic                shake_hit;
  logic [psd_pkg::PROD_W-1:0] ratio_diag;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign age     = cur_t_r - rd_data_r.stamp;
  assign expired = (age >= {16'd0, window_r});
  assign full    = (held_r == psd_pkg::CNT_W'(psd_pkg::HISTORY_DEPTH));

  assign tol_s = (CW + 2)'($signed({1'b0, tol_r}));
  assign ax = (CW + 1)'(last_x_r) - (CW + 1)'(rd_data_r.x);
  assign bx = (CW + 1)'(cur_x_r) - (CW + 1)'(last_x_r);
  assign ay = (CW + 1)'(last_y_r) - (CW + 1)'(rd_data_r.y);
  assign by = (CW + 1)'(cur_y_r) - (CW + 1)'(last_y_r);

  function automatic logic agree(logic signed [CW:0] a, logic signed [CW:0] b,
                                 logic signed [CW+1:0] t);
    logic signed [CW+1:0] ae, be;
    ae = (CW + 2)'(a);
    be = (CW + 2)'(b);
    return ((ae >= -t) && (be >= -t)) || ((ae <= t) && (be <= t));
  endfunction

  assign agree_ok = agree(ax, bx, tol_s) && agree(ay, by, tol_s);

  // Segment from the previous walked point to the one just read.
  assign sx = (CW + 1)'(rd_data_r.x) - (CW + 1)'(prev_x_r);
  assign sy = (CW + 1)'(rd_data_r.y) - (CW + 1)'(prev_y_r);
  assign mx = sx[CW] ? (CW + 1)'(-sx) : (CW + 1)'(sx);
  assign my = sy[CW] ? (CW + 1)'(-sy) : (CW + 1)'(sy);

  assign ratio_diag = psd_pkg::PROD_W'(ratio_r) * psd_pkg::PROD_W'(hyp_root);
  assign shake_hit  = (hyp_root >= psd_pkg::ROOT_W'(min_diag_r)) &&
                      (psd_pkg::CMP_W'(trail_r) > psd_pkg::CMP_W'(ratio_diag));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psd_pkg::ST_IDLE:      if (in_acc) state_nxt = psd_pkg::ST_AGE_RQ;
      psd_pkg::ST_AGE_RQ:    state_nxt = (held_r == '0) ? psd_pkg::ST_MRG_RQ1
                                                        : psd_pkg::ST_AGE_CK;
      psd_pkg::ST_AGE_CK:    state_nxt = expired ? psd_pkg::ST_AGE_RQ
                                                 : psd_pkg::ST_MRG_RQ1;
      psd_pkg::ST_MRG_RQ1:   state_nxt = (held_r >= psd_pkg::CNT_W'(2))
                                         ? psd_pkg::ST_MRG_RQ2 : psd_pkg::ST_APPEND;
      psd_pkg::ST_MRG_RQ2:   state_nxt = psd_pkg::ST_MRG_CK;
      psd_pkg::ST_MRG_CK:    state_nxt = agree_ok ? psd_pkg::ST_RESULT
                                                  : psd_pkg::ST_APPEND;
      psd_pkg::ST_APPEND:    state_nxt = (held_r != '0) ? psd_pkg::ST_WALK_RQ
                                                        : psd_pkg::ST_RESULT;
      psd_pkg::ST_WALK_RQ:   state_nxt = psd_pkg::ST_WALK_DAT;
      psd_pkg::ST_WALK_DAT:  state_nxt = (seg_cnt_r == '0) ? psd_pkg::ST_WALK_RQ
                                                           : psd_pkg::ST_WALK_WAIT;
      psd_pkg::ST_WALK_WAIT: begin
        if (hyp_stat.done) begin
          state_nxt = (seg_cnt_r + psd_pkg::CNT_W'(1) == held_r)
                      ? psd_pkg::ST_DIAG_GO : psd_pkg::ST_WALK_RQ;
        end
      end
      psd_pkg::ST_DIAG_GO:   state_nxt = psd_pkg::ST_DIAG_WAIT;
      psd_pkg::ST_DIAG_WAIT: if (hyp_stat.done) state_nxt = psd_pkg::ST_RESULT;
      psd_pkg::ST_RESULT:    if (!out_valid_r || out_ch.ready) state_nxt = psd_pkg::ST_IDLE;
      default:               state_nxt = psd_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ch.ready = (state_r == psd_pkg::ST_IDLE);
    rd_addr     = oldest_r;
    mem_we      = 1'b0;
    wr_addr     = next_r;
    wr_data     = '{x: cur_x_r, y: cur_y_r, stamp: cur_t_r};
    hyp_start   = 1'b0;
    hyp_a       = mx[psd_pkg::MAG_W-1:0];
    hyp_b       = my[psd_pkg::MAG_W-1:0];
    res_load    = 1'b0;
    case (state_r)
      psd_pkg::ST_MRG_RQ1: rd_addr = psd_pkg::slot_dec(next_r);
      psd_pkg::ST_MRG_RQ2: rd_addr = psd_pkg::slot_dec(psd_pkg::slot_dec(next_r));
      psd_pkg::ST_MRG_CK: begin
        mem_we  = agree_ok;
        wr_addr = psd_pkg::slot_dec(next_r);
      end
      psd_pkg::ST_APPEND:  mem_we = 1'b1;
      psd_pkg::ST_WALK_RQ: rd_addr = walk_idx_r;
      psd_pkg::ST_WALK_DAT: hyp_start = (seg_cnt_r != '0);
      psd_pkg::ST_DIAG_GO: begin
        hyp_start = 1'b1;
        hyp_a     = psd_pkg::MAG_W'((CW + 1)'(max_x_r) - (CW + 1)'(min_x_r));
        hyp_b     = psd_pkg::MAG_W'((CW + 1)'(max_y_r) - (CW + 1)'(min_y_r));
      end
      psd_pkg::ST_RESULT:  res_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  psd_hypot u_hypot (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hyp_start),
    .op_a  (hyp_a),
    .op_b  (hyp_b),
    .stat  (hyp_stat),
    .root  (hyp_root)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psd_pkg::ST_IDLE;
      oldest_r    <= '0;
      next_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        psd_pkg::ST_AGE_CK: begin
          if (expired) begin
            oldest_r <= psd_pkg::slot_inc(oldest_r);
            held_r   <= held_r - psd_pkg::CNT_W'(1);
          end
        end
        psd_pkg::ST_APPEND: begin
          // A full ring gives up its oldest point to the new one.
          if (full) begin
            oldest_r <= psd_pkg::slot_inc(oldest_r);
          end else begin
            held_r <= held_r + psd_pkg::CNT_W'(1);
          end
          next_r <= psd_pkg::slot_inc(next_r);
        end
        psd_pkg::ST_DIAG_WAIT: begin
          if (hyp_stat.done && shake_hit) begin
            oldest_r <= next_r;
            held_r   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      psd_pkg::ST_IDLE: begin
        cur_x_r <= in_ch.pos_x;
        cur_y_r <= in_ch.pos_y;
        cur_t_r <= in_ch.stamp_ms;
      end
      psd_pkg::ST_MRG_RQ2: begin
        last_x_r <= rd_data_r.x;
        last_y_r <= rd_data_r.y;
      end
      psd_pkg::ST_MRG_CK: res_shaken_r <= 1'b0;
      psd_pkg::ST_APPEND: begin
        walk_idx_r   <= full ? psd_pkg::slot_inc(oldest_r) : oldest_r;
        seg_cnt_r    <= '0;
        trail_r      <= '0;
        res_shaken_r <= 1'b0;
      end
      psd_pkg::ST_WALK_DAT: begin
        prev_x_r <= rd_data_r.x;
        prev_y_r <= rd_data_r.y;
        if (seg_cnt_r == '0) begin
          min_x_r    <= rd_data_r.x;
          max_x_r    <= rd_data_r.x;
          min_y_r    <= rd_data_r.y;
          max_y_r    <= rd_data_r.y;
          seg_cnt_r  <= psd_pkg::CNT_W'(1);
          walk_idx_r <= psd_pkg::slot_inc(walk_idx_r);
        end else begin
          if (rd_data_r.x < min_x_r) min_x_r <= rd_data_r.x;
          if (rd_data_r.x > max_x_r) max_x_r <= rd_data_r.x;
          if (rd_data_r.y < min_y_r) min_y_r <= rd_data_r.y;
          if (rd_data_r.y > max_y_r) max_y_r <= rd_data_r.y;
        end
      end
      psd_pkg::ST_WALK_WAIT: begin
        if (hyp_stat.done) begin
          trail_r    <= trail_r + psd_pkg::TRAIL_W'(hyp_root);
          seg_cnt_r  <= seg_cnt_r + psd_pkg::CNT_W'(1);
          walk_idx_r <= psd_pkg::slot_inc(walk_idx_r);
        end
      end
      psd_pkg::ST_DIAG_WAIT: if (hyp_stat.done) res_shaken_r <= shake_hit;
      default: ;
    endcase
    if (res_load) begin
      out_shaken_r <= res_shaken_r;
      out_count_r  <= 7'(held_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.shaken        = out_shaken_r;
  assign out_ch.history_count = out_count_r;

  `PSD_ASSERT_ALWAYS(a_held_bound, held_r <= psd_pkg::CNT_W'(psd_pkg::HISTORY_DEPTH), "history count overflow")
  `PSD_ASSERT_NEXT(a_accept_starts, in_acc, state_r == psd_pkg::ST_AGE_RQ, "accepted word did not start aging")
  `PSD_ASSERT_IMP(a_shake_clears, out_ch.valid && out_ch.shaken, out_ch.history_count == 7'd0, "shake left history")
  `PSD_ASSERT_ALWAYS(a_hyp_free, !(hyp_start && hyp_stat.busy), "root unit started while busy")
  `PSD_ASSERT_NEXT(a_idle_stable, (state_r == psd_pkg::ST_IDLE) && !in_acc, $stable(held_r), "history moved while idle")

endmodule
